// ----- rtl/slrp_pkg.sv -----
// Package for the server-list record parser.
// Holds the parse phase and event kind types, tag type codes and the result layout.
// Used by server_list_record_parser_top and tb_top; depends on nothing else.
`default_nettype none

package slrp_pkg;

  // Parse phases of the byte stream.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_COUNT   = 4'd1,
    PH_ADDR    = 4'd2,
    PH_PORT    = 4'd3,
    PH_TAGS    = 4'd4,
    PH_TYPE    = 4'd5,
    PH_NAMELEN = 4'd6,
    PH_NAME    = 4'd7,
    PH_VAL4    = 4'd8,
    PH_STRLEN  = 4'd9,
    PH_STR     = 4'd10
  } phase_t;

  // Kinds of result items.
  typedef enum logic [1:0] {
    EV_RECORD = 2'd0,
    EV_EMPTY  = 2'd1,
    EV_WARN   = 2'd2,
    EV_STOP   = 2'd3
  } event_kind_t;

  // Tag types that carry a value after the name.
  localparam logic [7:0] TAG_VAL4   = 8'h03;
  localparam logic [7:0] TAG_STRING = 8'h02;

  // Reset value of the record count warning limit.
  localparam logic [31:0] WARN_LIMIT_RESET = 32'd1024;

  // Result payload; the last member sits in the lowest bits.
  typedef struct packed {
    logic [31:0] list_count;
    logic [31:0] record_number;
    logic [31:0] record_tag_count;
    logic [15:0] server_port;
    logic [7:0]  octet_fourth;
    logic [7:0]  octet_third;
    logic [7:0]  octet_second;
    logic [7:0]  octet_first;
  } result_t;

  // Result item with its kind.
  typedef struct packed {
    event_kind_t kind;
    result_t     data;
  } result_item_t;

endpackage

`default_nettype wire

// ----- rtl/server_list_record_parser_top.sv -----
// Server-list record parser: byte-wide file parser with a two-entry result buffer.
// Depends on slrp_pkg for phase and event types and the result layout.
//
//   Channel   Ports                                 Width  Moves
//   input     in_tvalid/in_tready/in_tdata/in_tuser  8+1    one file byte per item
//   result    out_tvalid/out_tready/out_tdata/tuser  144+2  one event per item
//   config    cfg_we/cfg_wdata                       32     warning record limit
//
// One byte is taken per cycle while in_tready is high; its event, if any, is registered.
// The parser state updates in the cycle a byte is accepted, from one gather step.
// in_tready drops only while the second result register holds a stalled event.
// rst_n is synchronous and active low; it clears the parser and sets the limit to 1024.
`default_nettype none

module server_list_record_parser_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input item: data_byte [7:0].
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,
  // Input flag: start_of_file [0].
  input  wire logic         in_tuser,
  // Result item: octet_first [7:0], octet_second [15:8], octet_third [23:16],
  // octet_fourth [31:24], server_port [47:32], record_tag_count [79:48],
  // record_number [111:80], list_count [143:112].
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata,
  // Result kind: event_kind [1:0].
  output logic [1:0]        out_tuser,
  // Configuration: warn_record_limit.
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata
);

  // Parser state.
  slrp_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] done_r, done_nxt;
  logic [31:0] tags_r, tags_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  tag_type_r, tag_type_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] limit_r;

  // Output buffer.
  logic                   out_valid_r, skid_valid_r;
  slrp_pkg::result_item_t out_r, skid_r;
  slrp_pkg::result_item_t res;
  logic                   res_valid;

  logic        go;
  logic        start;
  logic [7:0]  b;
  logic        g_four;
  logic        g_last;
  logic [31:0] g_val;
  logic        last_rec;
  logic        last_tag;
  logic        name_stop;
  slrp_pkg::phase_t after_name_ph;
  slrp_pkg::phase_t end_rec_ph;
  slrp_pkg::phase_t end_tag_ph;

  assign in_tready = !skid_valid_r;
  assign go        = in_tvalid && in_tready;
  assign start     = in_tuser;
  assign b         = in_tdata;

  // Little-endian field gather: four-byte fields end at byte 3, two-byte fields at byte 1.
  assign g_four = (phase_r == slrp_pkg::PH_COUNT) || (phase_r == slrp_pkg::PH_ADDR) ||
                  (phase_r == slrp_pkg::PH_TAGS)  || (phase_r == slrp_pkg::PH_VAL4);
  assign g_last = g_four ? (idx_r == 2'd3) : (idx_r != 2'd0);
  assign g_val  = acc_r | ({24'd0, b} << {idx_r, 3'b000});

  // Phase that follows the end of a record, a tag or a name.
  assign last_rec   = ((done_r + 32'd1) == total_r);
  assign last_tag   = (tags_r == 32'd1);
  assign end_rec_ph = last_rec ? slrp_pkg::PH_IDLE : slrp_pkg::PH_ADDR;
  assign end_tag_ph = last_tag ? end_rec_ph : slrp_pkg::PH_TYPE;
  assign name_stop  = (tag_type_r != slrp_pkg::TAG_VAL4) &&
                      (tag_type_r != slrp_pkg::TAG_STRING);
  always_comb begin
    if (tag_type_r == slrp_pkg::TAG_VAL4) begin
      after_name_ph = slrp_pkg::PH_VAL4;
    end else if (tag_type_r == slrp_pkg::TAG_STRING) begin
      after_name_ph = slrp_pkg::PH_STRLEN;
    end else begin
      after_name_ph = slrp_pkg::PH_IDLE;
    end
  end

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    if (start) begin
      phase_nxt = slrp_pkg::PH_COUNT;
    end else begin
      unique case (phase_r)
        slrp_pkg::PH_COUNT: begin
          if (g_last) phase_nxt = (g_val == 32'd0) ? slrp_pkg::PH_IDLE : slrp_pkg::PH_ADDR;
        end
        slrp_pkg::PH_ADDR: begin
          if (g_last) phase_nxt = slrp_pkg::PH_PORT;
        end
        slrp_pkg::PH_PORT: begin
          if (g_last) phase_nxt = slrp_pkg::PH_TAGS;
        end
        slrp_pkg::PH_TAGS: begin
          if (g_last) phase_nxt = (g_val == 32'd0) ? end_rec_ph : slrp_pkg::PH_TYPE;
        end
        slrp_pkg::PH_TYPE: begin
          phase_nxt = slrp_pkg::PH_NAMELEN;
        end
        slrp_pkg::PH_NAMELEN: begin
          if (g_last) phase_nxt = (g_val[15:0] == 16'd0) ? after_name_ph : slrp_pkg::PH_NAME;
        end
        slrp_pkg::PH_NAME: begin
          if (skip_r == 16'd1) phase_nxt = after_name_ph;
        end
        slrp_pkg::PH_VAL4: begin
          if (g_last) phase_nxt = end_tag_ph;
        end
        slrp_pkg::PH_STRLEN: begin
          if (g_last) phase_nxt = (g_val[15:0] == 16'd0) ? end_tag_ph : slrp_pkg::PH_STR;
        end
        slrp_pkg::PH_STR: begin
          if (skip_r == 16'd1) phase_nxt = end_tag_ph;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Field registers, counters and the result of this byte.
  always_comb begin
    idx_nxt      = idx_r;
    acc_nxt      = acc_r;
    total_nxt    = total_r;
    done_nxt     = done_r;
    tags_nxt     = tags_r;
    skip_nxt     = skip_r;
    tag_type_nxt = tag_type_r;
    addr_nxt     = addr_r;
    port_nxt     = port_r;
    res_valid    = 1'b0;
    res          = '0;
    res.data.record_number = done_r;
    res.data.list_count    = total_r;

    if (start) begin
      idx_nxt      = '0;
      acc_nxt      = '0;
      total_nxt    = '0;
      done_nxt     = '0;
      tags_nxt     = '0;
      skip_nxt     = '0;
      tag_type_nxt = '0;
      addr_nxt     = '0;
      port_nxt     = '0;
    end else begin
      // Gather step shared by all multi-byte fields.
      if (g_four || (phase_r == slrp_pkg::PH_PORT) || (phase_r == slrp_pkg::PH_NAMELEN) ||
          (phase_r == slrp_pkg::PH_STRLEN)) begin
        idx_nxt = g_last ? 2'd0 : idx_r + 2'd1;
        acc_nxt = g_last ? 32'd0 : g_val;
      end

      case (phase_r)
        slrp_pkg::PH_COUNT: begin
          if (g_last) begin
            total_nxt = g_val;
            res.data.list_count = g_val;
            if (g_val == 32'd0) begin
              res_valid = 1'b1;
              res.kind  = slrp_pkg::EV_EMPTY;
            end else if (g_val > limit_r) begin
              res_valid = 1'b1;
              res.kind  = slrp_pkg::EV_WARN;
            end
          end
        end
        slrp_pkg::PH_ADDR: begin
          if (g_last) addr_nxt = g_val;
        end
        slrp_pkg::PH_PORT: begin
          if (g_last) port_nxt = g_val[15:0];
        end
        slrp_pkg::PH_TAGS: begin
          if (g_last) begin
            tags_nxt  = g_val;
            res_valid = 1'b1;
            res.kind  = slrp_pkg::EV_RECORD;
            res.data.octet_first      = addr_r[7:0];
            res.data.octet_second     = addr_r[15:8];
            res.data.octet_third      = addr_r[23:16];
            res.data.octet_fourth     = addr_r[31:24];
            res.data.server_port      = port_r;
            res.data.record_tag_count = g_val;
            if (g_val == 32'd0) done_nxt = done_r + 32'd1;
          end
        end
        slrp_pkg::PH_TYPE: begin
          tag_type_nxt = b;
        end
        slrp_pkg::PH_NAMELEN: begin
          if (g_last) begin
            skip_nxt = g_val[15:0];
            if ((g_val[15:0] == 16'd0) && name_stop) begin
              res_valid = 1'b1;
              res.kind  = slrp_pkg::EV_STOP;
            end
          end
        end
        slrp_pkg::PH_NAME: begin
          skip_nxt = skip_r - 16'd1;
          if ((skip_r == 16'd1) && name_stop) begin
            res_valid = 1'b1;
            res.kind  = slrp_pkg::EV_STOP;
          end
        end
        slrp_pkg::PH_VAL4: begin
          if (g_last) begin
            tags_nxt = tags_r - 32'd1;
            if (last_tag) done_nxt = done_r + 32'd1;
          end
        end
        slrp_pkg::PH_STRLEN: begin
          if (g_last) begin
            skip_nxt = g_val[15:0];
            if (g_val[15:0] == 16'd0) begin
              tags_nxt = tags_r - 32'd1;
              if (last_tag) done_nxt = done_r + 32'd1;
            end
          end
        end
        slrp_pkg::PH_STR: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) begin
            tags_nxt = tags_r - 32'd1;
            if (last_tag) done_nxt = done_r + 32'd1;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Parser registers advance on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= slrp_pkg::PH_IDLE;
      idx_r      <= '0;
      acc_r      <= '0;
      total_r    <= '0;
      done_r     <= '0;
      tags_r     <= '0;
      skip_r     <= '0;
      tag_type_r <= '0;
      addr_r     <= '0;
      port_r     <= '0;
    end else if (go) begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      acc_r      <= acc_nxt;
      total_r    <= total_nxt;
      done_r     <= done_nxt;
      tags_r     <= tags_nxt;
      skip_r     <= skip_nxt;
      tag_type_r <= tag_type_nxt;
      addr_r     <= addr_nxt;
      port_r     <= port_nxt;
    end
  end

  // Warning limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= slrp_pkg::WARN_LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Output register with a skid entry behind it.
  logic out_load;
  assign out_load = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r  <= skid_valid_r || (go && res_valid);
      skid_valid_r <= 1'b0;
    end else if (go && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (go && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.kind;

`ifndef SYNTHESIS
  // The skid entry is only filled behind a stalled output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while the output register is empty");

  // A result made while the output stalls lands in the skid entry.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_valid && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result lost while the output was stalled");

  // Phases without a multi-byte field leave the gather index at zero.
  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == slrp_pkg::PH_IDLE || phase_r == slrp_pkg::PH_TYPE ||
     phase_r == slrp_pkg::PH_NAME || phase_r == slrp_pkg::PH_STR) |-> (idx_r == 2'd0))
    else $error("gather index not cleared outside a field");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the server-list record parser: byte streams with random gaps and stalls.
// Predicts every event from its own parser model and compares each result item field by field.
// Depends on slrp_pkg and server_list_record_parser_top.
`default_nettype none

module tb_top;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  // Bytes the random test sends on top of the directed tests.
  localparam int unsigned RANDOM_ITEMS = 60;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  server_list_record_parser_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Largest gap each side may draw per item; zero gives back-to-back stretches.
  int unsigned in_gap_max = 7;
  int unsigned out_gap_max = 7;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  // Events predicted but not yet seen on the result channel, oldest first.
  slrp_pkg::result_item_t expected_events[$];

  // Parser model state.
  logic [31:0]      warn_threshold = slrp_pkg::WARN_LIMIT_RESET;
  slrp_pkg::phase_t parse_state = slrp_pkg::PH_IDLE;
  logic [1:0]       byte_pos = '0;
  logic [31:0]      field_acc = '0;
  logic [31:0]      hdr_count = '0;
  logic [31:0]      recs_finished = '0;
  logic [31:0]      tags_left = '0;
  logic [15:0]      skip_left = '0;
  logic [7:0]       tag_kind = '0;
  logic [31:0]      addr_word = '0;
  logic [15:0]      port_word = '0;

  // Collect one byte of an n-byte little-endian field; true once the field is whole.
  function automatic bit take_field(input logic [7:0] b, input int unsigned n,
                                    output logic [31:0] v);
    field_acc = field_acc | (32'(b) << (8 * byte_pos));
    v = field_acc;
    if (byte_pos + 1 >= n) begin
      field_acc = '0;
      byte_pos = '0;
      return 1'b1;
    end
    byte_pos = byte_pos + 2'd1;
    return 1'b0;
  endfunction

  function automatic void finish_record();
    recs_finished = recs_finished + 32'd1;
    if (recs_finished == hdr_count) begin
      parse_state = slrp_pkg::PH_IDLE;
    end else begin
      parse_state = slrp_pkg::PH_ADDR;
    end
  endfunction

  function automatic void finish_tag();
    tags_left = tags_left - 32'd1;
    if (tags_left == 0) begin
      finish_record();
    end else begin
      parse_state = slrp_pkg::PH_TYPE;
    end
  endfunction

  // The tag name is over: known types carry a value, any other type ends the list.
  function automatic bit name_done(inout slrp_pkg::result_item_t ev);
    if (tag_kind == slrp_pkg::TAG_VAL4) begin
      parse_state = slrp_pkg::PH_VAL4;
      return 1'b0;
    end
    if (tag_kind == slrp_pkg::TAG_STRING) begin
      parse_state = slrp_pkg::PH_STRLEN;
      return 1'b0;
    end
    ev.kind = slrp_pkg::EV_STOP;
    parse_state = slrp_pkg::PH_IDLE;
    return 1'b1;
  endfunction

  // Advance the model by one accepted byte; true when the byte raises an event.
  function automatic bit predict_byte(input logic [7:0] b, input logic sof,
                                      output slrp_pkg::result_item_t ev);
    logic [31:0] v;
    bit hit;
    ev = '0;
    v = '0;
    hit = 1'b0;
    if (sof) begin
      parse_state = slrp_pkg::PH_COUNT;
      byte_pos = '0;
      field_acc = '0;
      hdr_count = '0;
      recs_finished = '0;
      tags_left = '0;
      skip_left = '0;
      tag_kind = '0;
      addr_word = '0;
      port_word = '0;
      return 1'b0;
    end
    case (parse_state)
      slrp_pkg::PH_COUNT: begin
        if (take_field(b, 4, v)) begin
          hdr_count = v;
          if (v == 0) begin
            ev.kind = slrp_pkg::EV_EMPTY;
            hit = 1'b1;
            parse_state = slrp_pkg::PH_IDLE;
          end else begin
            parse_state = slrp_pkg::PH_ADDR;
            if (v > warn_threshold) begin
              ev.kind = slrp_pkg::EV_WARN;
              hit = 1'b1;
            end
          end
        end
      end
      slrp_pkg::PH_ADDR: begin
        if (take_field(b, 4, v)) begin
          addr_word = v;
          parse_state = slrp_pkg::PH_PORT;
        end
      end
      slrp_pkg::PH_PORT: begin
        if (take_field(b, 2, v)) begin
          port_word = v[15:0];
          parse_state = slrp_pkg::PH_TAGS;
        end
      end
      slrp_pkg::PH_TAGS: begin
        if (take_field(b, 4, v)) begin
          tags_left = v;
          ev.kind = slrp_pkg::EV_RECORD;
          ev.data.octet_first = addr_word[7:0];
          ev.data.octet_second = addr_word[15:8];
          ev.data.octet_third = addr_word[23:16];
          ev.data.octet_fourth = addr_word[31:24];
          ev.data.server_port = port_word;
          ev.data.record_tag_count = v;
          ev.data.record_number = recs_finished;
          ev.data.list_count = hdr_count;
          hit = 1'b1;
          if (v == 0) begin
            finish_record();
          end else begin
            parse_state = slrp_pkg::PH_TYPE;
          end
        end
      end
      slrp_pkg::PH_TYPE: begin
        tag_kind = b;
        parse_state = slrp_pkg::PH_NAMELEN;
      end
      slrp_pkg::PH_NAMELEN: begin
        if (take_field(b, 2, v)) begin
          skip_left = v[15:0];
          if (skip_left == 0) begin
            hit = name_done(ev);
          end else begin
            parse_state = slrp_pkg::PH_NAME;
          end
        end
      end
      slrp_pkg::PH_NAME: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) begin
          hit = name_done(ev);
        end
      end
      slrp_pkg::PH_VAL4: begin
        if (take_field(b, 4, v)) begin
          finish_tag();
        end
      end
      slrp_pkg::PH_STRLEN: begin
        if (take_field(b, 2, v)) begin
          skip_left = v[15:0];
          if (skip_left == 0) begin
            finish_tag();
          end else begin
            parse_state = slrp_pkg::PH_STR;
          end
        end
      end
      slrp_pkg::PH_STR: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) begin
          finish_tag();
        end
      end
      default: begin
      end
    endcase
    // Error and warning events carry only the record progress and the header count.
    if (hit && ev.kind != slrp_pkg::EV_RECORD) begin
      ev.data.record_number = recs_finished;
      ev.data.list_count = hdr_count;
    end
    return hit;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one accepted result item with the oldest predicted event.
  function automatic void compare_event(input logic [1:0] kind, input logic [143:0] payload);
    slrp_pkg::result_item_t want;
    slrp_pkg::result_t got;
    got = slrp_pkg::result_t'(payload);
    if (expected_events.size() == 0) begin
      $error("result item with no event expected: kind %0d", kind);
      mismatches++;
      return;
    end
    want = expected_events.pop_front();
    check_field("event_kind", 32'(want.kind), 32'(kind));
    check_field("octet_first", 32'(want.data.octet_first), 32'(got.octet_first));
    check_field("octet_second", 32'(want.data.octet_second), 32'(got.octet_second));
    check_field("octet_third", 32'(want.data.octet_third), 32'(got.octet_third));
    check_field("octet_fourth", 32'(want.data.octet_fourth), 32'(got.octet_fourth));
    check_field("server_port", 32'(want.data.server_port), 32'(got.server_port));
    check_field("record_tag_count", want.data.record_tag_count, got.record_tag_count);
    check_field("record_number", want.data.record_number, got.record_number);
    check_field("list_count", want.data.list_count, got.list_count);
  endfunction

  // Result side: stall a random number of cycles, then take one item and check it.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      compare_event(out_tuser, out_tdata);
    end
  end

  // End the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one byte after a random gap and feed it to the model once accepted.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int unsigned gap;
    slrp_pkg::result_item_t ev;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= sof;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (predict_byte(b, sof, ev)) begin
      expected_events.push_back(ev);
    end
  endtask

  task automatic send_le(input logic [31:0] value, input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(value[8*i +: 8], 1'b0);
    end
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_header(input logic [31:0] count);
    send_byte(8'($urandom), 1'b1);
    send_le(count, 4);
  endtask

  task automatic send_record(input logic [31:0] addr, input logic [15:0] port,
                             input logic [31:0] ntags);
    send_le(addr, 4);
    send_le(32'(port), 2);
    send_le(ntags, 4);
  endtask

  // A tag: type byte, name, then the value that the type calls for.
  task automatic send_tag(input logic [7:0] code, input int unsigned name_len,
                          input int unsigned str_len);
    send_byte(code, 1'b0);
    send_le(name_len, 2);
    send_noise(name_len);
    if (code == slrp_pkg::TAG_VAL4) begin
      send_le($urandom, 4);
    end else if (code == slrp_pkg::TAG_STRING) begin
      send_le(str_len, 2);
      send_noise(str_len);
    end
  endtask

  // Wait until every predicted event has arrived and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    warn_threshold = value;
  endtask

  // Short names and strings keep the random files brief.
  function automatic int unsigned random_len();
    return $urandom_range(0, 3);
  endfunction

  // One file with random content: mostly well formed, sometimes cut short or stopped.
  task automatic random_file();
    logic [31:0] count;
    int unsigned nrec;
    int unsigned ntags;
    logic [7:0] code;
    bit cut;
    case ($urandom_range(0, 9))
      0: count = '0;
      1: count = $urandom | 32'h8000_0000;
      default: count = $urandom_range(1, 4);
    endcase
    send_header(count);
    if (count == 0) begin
      send_noise($urandom_range(0, 3));
      return;
    end
    cut = (count > 4) || ($urandom_range(0, 7) == 0);
    nrec = (count > 4) ? $urandom_range(1, 3) : count;
    for (int r = 0; r < nrec; r++) begin
      // A cut file ends inside a record, before its tag count is complete.
      if (cut && r == nrec - 1) begin
        send_noise($urandom_range(1, 9));
        return;
      end
      ntags = $urandom_range(0, 3);
      send_record($urandom, 16'($urandom), ntags);
      for (int t = 0; t < ntags; t++) begin
        if ($urandom_range(0, 19) == 0) begin
          do code = 8'($urandom);
          while (code == slrp_pkg::TAG_VAL4 || code == slrp_pkg::TAG_STRING);
          send_tag(code, random_len(), 0);
          send_noise($urandom_range(0, 3));
          return;
        end
        send_tag(($urandom_range(0, 1) != 0) ? slrp_pkg::TAG_VAL4 : slrp_pkg::TAG_STRING,
                 random_len(), random_len());
      end
    end
    send_noise($urandom_range(0, 3));
  endtask

  // Bytes before any start flag are ignored.
  task automatic test_bytes_before_start();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_noise(3);
  endtask

  // A zero record count is an error; the bytes after it are ignored.
  task automatic test_empty_list();
    send_header('0);
    send_noise(3);
  endtask

  // A complete list with extreme fields, both value types, empty names and a tagless record.
  task automatic test_complete_list();
    send_byte(8'hFF, 1'b1);
    send_le(32'd3, 4);
    send_record(32'hFFFF_FFFF, 16'hFFFF, 32'd2);
    send_tag(slrp_pkg::TAG_VAL4, 2, 0);
    send_tag(slrp_pkg::TAG_STRING, 0, 0);
    send_record(32'h0000_0000, 16'h0000, 32'd0);
    send_record(32'h0A0B_0C0D, 16'h1234, 32'd1);
    send_tag(slrp_pkg::TAG_STRING, 1, 3);
    send_noise(4);
  endtask

  // Unknown tag types stop the list, right after the name.
  task automatic test_unknown_tag();
    send_header(32'd2);
    send_record($urandom, 16'($urandom), 32'h8000_0001);
    send_tag(8'h07, 0, 0);
    send_noise(2);
    send_header(32'd1);
    send_record($urandom, 16'($urandom), 32'd1);
    send_tag(8'h00, 2, 0);
    send_header(32'd3);
    send_record($urandom, 16'($urandom), 32'd0);
    send_record($urandom, 16'($urandom), 32'd1);
    send_tag(8'hFF, 1, 0);
    send_noise(2);
  endtask

  // A start flag in mid-file throws away the list in progress.
  task automatic test_restart();
    send_header(32'd5);
    send_record($urandom, 16'($urandom), 32'd1);
    send_tag(slrp_pkg::TAG_VAL4, 1, 0);
    send_noise(2);
    send_header(32'd1);
    send_record($urandom, 16'($urandom), 32'd1);
    send_byte(slrp_pkg::TAG_STRING, 1'b0);
    send_le(32'd3, 2);
    send_noise(1);
    send_header(32'd2);
    send_record($urandom, 16'($urandom), 32'd0);
    send_record($urandom, 16'($urandom), 32'd0);
  endtask

  // Record counts around the warning limit at its extremes and its reset value.
  task automatic test_warn_limit();
    write_limit('0);
    send_header(32'd1);
    send_record($urandom, 16'($urandom), 32'd0);
    write_limit(32'd1);
    send_header(32'd2);
    send_header(32'd1);
    send_record($urandom, 16'($urandom), 32'd0);
    write_limit(slrp_pkg::WARN_LIMIT_RESET);
    send_header(slrp_pkg::WARN_LIMIT_RESET + 32'd1);
    send_header(slrp_pkg::WARN_LIMIT_RESET);
    send_record($urandom, 16'($urandom), 32'd0);
    write_limit(32'hFFFF_FFFF);
    send_header(32'hFFFF_FFFF);
    send_record($urandom, 16'($urandom), 32'd0);
    write_limit(slrp_pkg::WARN_LIMIT_RESET);
  endtask

  // A string length above 255 exercises the upper length byte.
  task automatic test_long_fields();
    send_header(32'd1);
    send_record($urandom, 16'($urandom), 32'd1);
    send_tag(slrp_pkg::TAG_STRING, 0, 256);
  endtask

  // Random files with limit changes and idle patterns between them.
  task automatic test_random_lists();
    int unsigned sent_base;
    logic [31:0] limit;
    sent_base = items_sent;
    while (items_sent - sent_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0: limit = '0;
          1: limit = 32'd1;
          2: limit = 32'd2;
          3: limit = 32'hFFFF_FFFF;
          4: limit = slrp_pkg::WARN_LIMIT_RESET;
          default: limit = $urandom;
        endcase
        write_limit(limit);
      end
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      random_file();
    end
  endtask

  initial begin : main_sequence
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_bytes_before_start();
    test_empty_list();
    test_complete_list();
    test_unknown_tag();
    test_restart();
    test_warn_limit();
    test_long_fields();
    test_random_lists();
    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
